// ----- rtl/decreasing_chain_counter_core_assert.svh -----
// Assertion macros for the chain counter core
`ifndef DECREASING_CHAIN_COUNTER_CORE_ASSERT_SVH
`define DECREASING_CHAIN_COUNTER_CORE_ASSERT_SVH

// clocked check, masked during reset
`define DCC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked check, live during reset
`define DCC_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/dcc_pkg.sv -----
`timescale 1ns / 1ps
package dcc_pkg;

   localparam int LEAVES     = 4096;
   localparam int LEAF_BITS  = 12;
   localparam int MAX_CHAIN  = 10;
   localparam int TABLES     = MAX_CHAIN - 1;
   localparam int MEM_DEPTH  = TABLES * LEAVES;
   localparam int ADDR_BITS  = 16;
   localparam int LVL_W      = 4;
   localparam int VAL_W      = 13;
   localparam int POS_W      = 14;
   localparam int CNT_W      = 30;
   localparam logic [CNT_W-1:0] COUNT_MOD = 30'd1000000000;
   localparam logic [LVL_W-1:0] CHAIN_RESET = 4'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PCHK,
      ST_PACC,
      ST_UCHK,
      ST_UWR,
      ST_TOTAL,
      ST_FINISH,
      ST_CLEAR
   } dcc_state_type;

   typedef struct packed {
      logic accept;
      logic rd_prev;
      logic p_done;
      logic p_acc;
      logic u_done;
      logic u_write;
      logic add_total;
      logic emit;
      logic clr_write;
   } dcc_cmd_type;

   typedef struct packed {
      logic item_ok;
      logic pos_zero;
      logic p_last;
      logic pos_out;
      logic u_last;
      logic last_item;
      logic rsp_busy;
      logic clr_done;
   } dcc_status_type;

   function automatic logic [CNT_W-1:0] add_mod(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, COUNT_MOD}) begin
         s = s - {1'b0, COUNT_MOD};
      end
      return s[CNT_W-1:0];
   endfunction

endpackage

// ----- rtl/decreasing_chain_counter_core.sv -----
`timescale 1ns / 1ps
// Counts strictly decreasing subsequences of length chain_length (1..10) in a
// stream of values 1..4096, modulo 1e9, and returns the count on the item
// marked tlast; values outside the range are skipped and flagged in tuser.
// Items are taken one at a time. Each valid item walks nine Fenwick prefix
// sums and nine Fenwick updates through one single-port-read table memory,
// one tree node at a time. A prefix and an update at one level always visit
// 13 nodes together, so every valid item takes the same time; an out-of-range
// item skips the walk. A last item also waits in its final cycle until the
// previous result has been taken. After reset and after every result the
// table memory is cleared in a pass over all 36864 words, during which no
// item is taken.
module decreasing_chain_counter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [12:0] value
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [29:0] total_count
   output logic        rsp_tuser,   // [0] value_out_of_range
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata
);

   dcc_pkg::dcc_cmd_type    cmd;
   dcc_pkg::dcc_status_type sts;

   dcc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   dcc_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

endmodule

// ----- rtl/dcc_ctrl.sv -----
`timescale 1ns / 1ps
module dcc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  dcc_pkg::dcc_status_type sts,
   output dcc_pkg::dcc_cmd_type    cmd
);

   dcc_pkg::dcc_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dcc_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         dcc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = sts.item_ok ? dcc_pkg::ST_PCHK : dcc_pkg::ST_FINISH;
            end
         end
         dcc_pkg::ST_PCHK: begin
            cmd.rd_prev = 1'b1;
            if (sts.pos_zero) begin
               cmd.p_done = 1'b1;
               if (sts.p_last) begin
                  state_in = dcc_pkg::ST_UCHK;
               end
            end else begin
               state_in = dcc_pkg::ST_PACC;
            end
         end
         dcc_pkg::ST_PACC: begin
            cmd.rd_prev = 1'b1;
            cmd.p_acc   = 1'b1;
            state_in    = dcc_pkg::ST_PCHK;
         end
         dcc_pkg::ST_UCHK: begin
            if (sts.pos_out) begin
               cmd.u_done = 1'b1;
               if (sts.u_last) begin
                  state_in = dcc_pkg::ST_TOTAL;
               end
            end else begin
               state_in = dcc_pkg::ST_UWR;
            end
         end
         dcc_pkg::ST_UWR: begin
            cmd.u_write = 1'b1;
            state_in    = dcc_pkg::ST_UCHK;
         end
         dcc_pkg::ST_TOTAL: begin
            cmd.add_total = 1'b1;
            state_in      = dcc_pkg::ST_FINISH;
         end
         dcc_pkg::ST_FINISH: begin
            if (!sts.last_item) begin
               state_in = dcc_pkg::ST_IDLE;
            end else if (!sts.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = dcc_pkg::ST_CLEAR;
            end
         end
         dcc_pkg::ST_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (sts.clr_done) begin
               state_in = dcc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dcc_pkg::ST_CLEAR;
         end
      endcase
   end

endmodule

// ----- rtl/dcc_datapath.sv -----
`timescale 1ns / 1ps
module dcc_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  dcc_pkg::dcc_cmd_type    cmd,
   output dcc_pkg::dcc_status_type sts,
   input  logic [15:0]             req_tdata,
   input  logic                    req_tlast,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [31:0]             rsp_tdata,
   output logic                    rsp_tuser,
   input  logic                    csr_we,
   input  logic [3:0]              csr_wdata
);

   logic [dcc_pkg::CNT_W-1:0]     mem [dcc_pkg::MEM_DEPTH];
   logic [dcc_pkg::CNT_W-1:0]     rd_data_ff;
   logic [dcc_pkg::CNT_W-1:0]     c_ff [dcc_pkg::MAX_CHAIN];
   logic [dcc_pkg::CNT_W-1:0]     acc_ff, total_ff, rsp_count_ff;
   logic [dcc_pkg::CNT_W-1:0]     cval, kval, wr_data;
   logic [dcc_pkg::LVL_W-1:0]     level_ff, chain_ff, tbl, ksel;
   logic [dcc_pkg::POS_W-1:0]     pos_ff, r_ff, r_in;
   logic [dcc_pkg::ADDR_BITS-1:0] clr_addr_ff, addr, wr_addr;
   logic [dcc_pkg::VAL_W-1:0]     value;
   logic                          last_ff, err_ff, rsp_valid_ff, rsp_err_ff, we;

   assign value = req_tdata[dcc_pkg::VAL_W-1:0];
   assign r_in  = dcc_pkg::POS_W'(dcc_pkg::LEAVES + 1) - {1'b0, value};
   assign tbl   = cmd.rd_prev ? level_ff - 4'd1 : level_ff;
   assign addr  = {tbl, pos_ff[dcc_pkg::LEAF_BITS-1:0]};
   assign cval  = (level_ff == '0) ? dcc_pkg::CNT_W'(1) : c_ff[level_ff];

   always_comb begin
      priority if (chain_ff == '0) begin
         ksel = '0;
      end else if (chain_ff > dcc_pkg::LVL_W'(dcc_pkg::MAX_CHAIN)) begin
         ksel = dcc_pkg::LVL_W'(dcc_pkg::MAX_CHAIN - 1);
      end else begin
         ksel = chain_ff - 4'd1;
      end
   end
   assign kval = (ksel == '0) ? dcc_pkg::CNT_W'(1) : c_ff[ksel];

   assign we      = cmd.clr_write | cmd.u_write;
   assign wr_addr = cmd.clr_write ? clr_addr_ff : addr;
   assign wr_data = cmd.clr_write ? '0 : dcc_pkg::add_mod(rd_data_ff, cval);

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign sts.item_ok   = (value != '0) && (value <= dcc_pkg::VAL_W'(dcc_pkg::LEAVES));
   assign sts.pos_zero  = (pos_ff == '0);
   assign sts.p_last    = (level_ff == dcc_pkg::LVL_W'(dcc_pkg::MAX_CHAIN - 1));
   assign sts.pos_out   = (pos_ff > dcc_pkg::POS_W'(dcc_pkg::LEAVES));
   assign sts.u_last    = (level_ff == dcc_pkg::LVL_W'(dcc_pkg::TABLES - 1));
   assign sts.last_item = last_ff;
   assign sts.rsp_busy  = rsp_valid_ff;
   assign sts.clr_done  = (clr_addr_ff == dcc_pkg::ADDR_BITS'(dcc_pkg::MEM_DEPTH - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff     <= dcc_pkg::CHAIN_RESET;
         total_ff     <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         clr_addr_ff  <= '0;
         last_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            chain_ff <= csr_wdata;
         end
         if (cmd.accept) begin
            last_ff <= req_tlast;
            if (!sts.item_ok) begin
               err_ff <= 1'b1;
            end
         end
         if (cmd.add_total) begin
            total_ff <= dcc_pkg::add_mod(total_ff, kval);
         end
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
            total_ff     <= '0;
            err_ff       <= 1'b0;
         end
         if (cmd.clr_write) begin
            clr_addr_ff <= sts.clr_done ? '0 : clr_addr_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         r_ff     <= r_in;
         level_ff <= 4'd1;
         pos_ff   <= r_in - 14'd1;
         acc_ff   <= '0;
      end
      if (cmd.p_done) begin
         c_ff[level_ff] <= acc_ff;
         acc_ff         <= '0;
         if (sts.p_last) begin
            level_ff <= '0;
            pos_ff   <= r_ff;
         end else begin
            level_ff <= level_ff + 4'd1;
            pos_ff   <= r_ff - 14'd1;
         end
      end
      if (cmd.p_acc) begin
         acc_ff <= dcc_pkg::add_mod(acc_ff, rd_data_ff);
         pos_ff <= pos_ff & (pos_ff - 14'd1);
      end
      if (cmd.u_done) begin
         level_ff <= level_ff + 4'd1;
         pos_ff   <= r_ff;
      end
      if (cmd.u_write) begin
         pos_ff <= pos_ff + (pos_ff & (~pos_ff + 14'd1));
      end
      if (cmd.emit) begin
         rsp_count_ff <= total_ff;
         rsp_err_ff   <= err_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_count_ff};
   assign rsp_tuser  = rsp_err_ff;

endmodule

// ----- rtl/dcc_checker.sv -----
`timescale 1ns / 1ps
`include "decreasing_chain_counter_core_assert.svh"
module dcc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        csr_we,
   input logic [3:0]  csr_wdata
);

   `DCC_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result dropped or changed while stalled")
   `DCC_ASSERT(a_one_at_a_time, req_tvalid && req_tready |=> !req_tready, "item taken while another is in work")
   `DCC_ASSERT(a_no_result_mid_run, req_tvalid && req_tready && !req_tlast |=> !$rose(rsp_tvalid), "result without a last transaction")
   `DCC_ASSERT_RST(a_reset_clear, reset |=> !req_tready && !rsp_tvalid, "busy clear or stale result after reset")

endmodule

bind decreasing_chain_counter_core dcc_checker u_dcc_checker (.*);

// ----- tb/decreasing_chain_counter_core_tb.sv -----
`timescale 1ns / 1ps
module decreasing_chain_counter_core_tb;
   import dcc_pkg::*;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic             last_item;
   } seq_item_t;

   typedef struct packed {
      logic [CNT_W-1:0] total_count;
      logic             value_out_of_range;
   } chain_result_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we;
   logic [3:0]  csr_wdata;

   seq_item_t     pending_items[$];
   chain_result_t expected_totals[$];
   seq_item_t     cur_item;
   int            send_gap;
   int            rsp_stall;
   bit            no_idle;
   int            fail_count;
   int            items_made;
   int            seqs_made;

   logic [3:0]       len_shadow;
   logic [CNT_W-1:0] chain_tbl[MAX_CHAIN][LEAVES+1];
   logic [CNT_W-1:0] chain_total;
   logic             range_flag;

   decreasing_chain_counter_core DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [CNT_W-1:0] sum_mod_1e9(logic [CNT_W-1:0] a,
                                                    logic [CNT_W-1:0] b);
      longint s;
      s = longint'(a) + longint'(b);
      if (s >= 1000000000) s = s - 1000000000;
      return s[CNT_W-1:0];
   endfunction

   function automatic logic [CNT_W-1:0] larger_sum(int lvl, int pos);
      logic [CNT_W-1:0] s;
      s = '0;
      while (pos >= 1) begin
         s = sum_mod_1e9(s, chain_tbl[lvl][pos]);
         pos = pos & (pos - 1);
      end
      return s;
   endfunction

   function automatic void chain_add(int lvl, int pos, logic [CNT_W-1:0] d);
      while (pos >= 1 && pos <= LEAVES) begin
         chain_tbl[lvl][pos] = sum_mod_1e9(chain_tbl[lvl][pos], d);
         pos = pos + (pos & -pos);
      end
   endfunction

   function automatic void clear_counts();
      foreach (chain_tbl[i, j]) chain_tbl[i][j] = '0;
      chain_total = '0;
      range_flag = 1'b0;
   endfunction

   function automatic void count_item(seq_item_t it);
      logic [CNT_W-1:0] c[MAX_CHAIN];
      chain_result_t    res;
      int               k;
      int               r;
      k = (len_shadow == 0) ? 1 : ((len_shadow > MAX_CHAIN) ? MAX_CHAIN : len_shadow);
      if (it.value >= 1 && it.value <= LEAVES) begin
         r = LEAVES + 1 - int'(it.value);
         c[0] = 1;
         for (int j = 1; j < MAX_CHAIN; j++) c[j] = larger_sum(j - 1, r - 1);
         for (int j = 0; j < MAX_CHAIN; j++) if (c[j] != 0) chain_add(j, r, c[j]);
         chain_total = sum_mod_1e9(chain_total, c[k-1]);
      end else begin
         range_flag = 1'b1;
      end
      if (it.last_item) begin
         res.total_count = chain_total;
         res.value_out_of_range = range_flag;
         expected_totals.push_back(res);
         clear_counts();
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tlast <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) count_item(cur_item);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               cur_item = pending_items.pop_front();
               req_tdata <= {3'b000, cur_item.value};
               req_tlast <= cur_item.last_item;
               req_tvalid <= 1'b1;
               send_gap <= no_idle ? 0 : $urandom_range(0, 18);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      chain_result_t exp_r;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_totals.size() == 0) begin
               $error("unexpected transaction: total_count %0d", rsp_tdata[29:0]);
               fail_count++;
            end else begin
               exp_r = expected_totals.pop_front();
               if (rsp_tdata[29:0] !== exp_r.total_count) begin
                  $error("total_count expected %0d actual %0d",
                         exp_r.total_count, rsp_tdata[29:0]);
                  fail_count++;
               end
               if (rsp_tuser !== exp_r.value_out_of_range) begin
                  $error("value_out_of_range expected %0d actual %0d",
                         exp_r.value_out_of_range, rsp_tuser);
                  fail_count++;
               end
            end
            rsp_stall <= no_idle ? 0 : $urandom_range(0, 18);
            rsp_tready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic push_item(int v, bit last);
      seq_item_t it;
      it.value = v[VAL_W-1:0];
      it.last_item = last;
      pending_items.push_back(it);
      items_made++;
   endtask

   task automatic wait_idle();
      while (pending_items.size() != 0 || req_tvalid || expected_totals.size() != 0)
         @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   task automatic write_length(int len);
      wait_idle();
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= len[3:0];
      len_shadow = len[3:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_sequence();
      int n;
      int alpha;
      int v;
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : $urandom_range(20, 70);
      alpha = ($urandom_range(0, 1) == 0) ? $urandom_range(2, 30) : LEAVES;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 39))
            0: v = 0;
            1: v = $urandom_range(LEAVES + 1, 8191);
            2: v = ($urandom_range(0, 1) == 0) ? 1 : LEAVES;
            default: v = (alpha == LEAVES) ? $urandom_range(1, LEAVES)
                                            : $urandom_range(LEAVES - alpha, LEAVES);
         endcase
         push_item(v, i == n - 1);
      end
      seqs_made++;
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      no_idle = 1'b0;
      fail_count = 0;
      items_made = 0;
      seqs_made = 0;
      len_shadow = CHAIN_RESET;
      clear_counts();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset length, out-of-range in the middle
      push_item(LEAVES, 0); push_item(3000, 0); push_item(2000, 0);
      push_item(0, 0); push_item(1, 0); push_item(1, 1);
      write_length(1);
      push_item(8191, 0); push_item(5, 0); push_item(LEAVES + 1, 0); push_item(7, 1);
      write_length(0);
      push_item(9, 0); push_item(4, 1);
      write_length(10);
      for (int i = 0; i < 10; i++) push_item(LEAVES - 100 * i, 0);
      push_item(1, 1);
      write_length(15);
      push_item(40, 0); push_item(30, 0); push_item(6144, 1);
      write_length(2);
      push_item(0, 1);

      while (items_made < 1650 || seqs_made < 30) begin
         if ($urandom_range(0, 2) == 0)
            write_length(($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                     : $urandom_range(1, 10));
         wait_idle();
         no_idle = ($urandom_range(0, 3) == 0);
         random_sequence();
      end

      wait_idle();
      if (fail_count == 0)
         $display("decreasing_chain_counter_core verification clean");
      else
         $display("decreasing_chain_counter_core verification failed");
      $finish;
   end

   initial begin
      #60000000;
      $display("decreasing_chain_counter_core verification failed");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/dcc_pkg.sv
rtl/dcc_ctrl.sv
rtl/dcc_datapath.sv
rtl/decreasing_chain_counter_core.sv
rtl/dcc_checker.sv
tb/decreasing_chain_counter_core_tb.sv
